/* rtl/rer_pkg.sv */
// ----------------------------------------------------------------------------
// rer_pkg
// Shared types, constants and helpers of the radial reprojection error block.
// ----------------------------------------------------------------------------
package rer_pkg;

    // store geometry
    localparam int MaxCameras = 1024;
    localparam int Words      = 15;
    localparam int WordW      = 32;
    localparam int CamIdxW    = 10;
    localparam int WordSelW   = 4;

    // camera word positions
    localparam logic [WordSelW-1:0] WordSelLast = 4'd14;
    localparam int WordTx = 9;
    localparam int WordF  = 12;
    localparam int WordK1 = 13;
    localparam int WordK2 = 14;

    // request commands
    localparam logic CmdLoad = 1'b0;
    localparam logic CmdEval = 1'b1;

    // result status codes
    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StZero = 2'd1;
    localparam logic [1:0] StSat  = 2'd2;

    // datapath widths: camera-frame point, its magnitude, divider remainder
    localparam int XcW  = 52;
    localparam int AbsW = XcW - 1;
    localparam int RemW = AbsW + 4;
    localparam int QW   = 32;

    // 1.0 in Q2.30
    localparam logic signed [63:0] OneQ30 = 64'sd1073741824;

    typedef logic [Words-1:0][WordW-1:0] t_cam_words;

    typedef struct packed {
        logic                      cmd;
        logic [CamIdxW-1:0]        cam_index;
        logic [WordSelW-1:0]       word_sel;
        logic signed [WordW-1:0]   load_value;
        logic signed [WordW-1:0]   point_x;
        logic signed [WordW-1:0]   point_y;
        logic signed [WordW-1:0]   point_z;
        logic signed [WordW-1:0]   meas_u;
        logic signed [WordW-1:0]   meas_v;
    } t_req;

    typedef struct packed {
        logic signed [WordW-1:0]   err_u;
        logic signed [WordW-1:0]   err_v;
        logic [1:0]                status;
    } t_rsp;

    // observation fields that enter the transform
    typedef struct packed {
        logic signed [WordW-1:0]   point_x;
        logic signed [WordW-1:0]   point_y;
        logic signed [WordW-1:0]   point_z;
        logic signed [WordW-1:0]   meas_u;
        logic signed [WordW-1:0]   meas_v;
    } t_obs;

    // fields riding alongside the divider and distortion pipe
    typedef struct packed {
        logic signed [WordW-1:0]   meas_u;
        logic signed [WordW-1:0]   meas_v;
        logic signed [WordW-1:0]   f;
        logic signed [WordW-1:0]   k1;
        logic signed [WordW-1:0]   k2;
        logic                      zero;
    } t_side;

    // saturate to 32 bits signed; top bit flags clipping
    function automatic logic [WordW:0] sat32(input logic signed [63:0] v);
        logic [WordW:0] res;
        if (v > 64'sd2147483647) begin
            res = {1'b1, 32'h7fff_ffff};
        end else if (v < -64'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[WordW-1:0]};
        end
        return res;
    endfunction

endpackage

/* rtl/rer_req_if.sv */
// ----------------------------------------------------------------------------
// rer_req_if
// Request channel: camera word loads and observations.
// ----------------------------------------------------------------------------
interface rer_req_if;
    logic          valid;
    logic          ready;
    rer_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rer_rsp_if.sv */
// ----------------------------------------------------------------------------
// rer_rsp_if
// Response channel: residual and status of one observation.
// ----------------------------------------------------------------------------
interface rer_rsp_if;
    logic          valid;
    logic          ready;
    rer_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/reprojection_error_radial.sv */
// ----------------------------------------------------------------------------
// reprojection_error_radial
// Reprojection residual of one observation under a pinhole camera with
// two-term radial distortion; camera parameters kept in an on-chip store.
//
//   channel   dir   payload                                        per request
//   i_req     in    cmd, cam_index, word_sel, load_value, point,   load or eval
//                   meas_u, meas_v
//   o_rsp     out   err_u, err_v, status                           eval only
//
// One request is taken every cycle while the skid register is empty, loads
// and evaluations mixed freely. An evaluation's accepting edge registers the
// store read; it then passes the rigid transform, the bit-per-stage divider
// and the distortion and residual stages before its response is offered. A
// load writes its word at acceptance, so any later evaluation sees it. When a
// response is held back, a skid register takes it and i_req.ready drops in
// the cycle after; the store needs no clearing after reset.
// ----------------------------------------------------------------------------
module reprojection_error_radial #(
    parameter int MAX_CAMERAS = rer_pkg::MaxCameras
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rer_req_if.sink        i_req,
    rer_rsp_if.source      o_rsp
);

    localparam int CamAw = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;

    logic                    w_en;
    logic                    w_acc;
    logic                    w_cam_ok;
    logic                    w_we;
    logic [CamAw-1:0]        w_addr;
    rer_pkg::t_cam_words     w_rd;
    rer_pkg::t_cam_words     w_words;

    logic                    r_s1_v;
    logic                    r_s1_ok;
    rer_pkg::t_obs           r_s1_obs;

    logic                    x_v;
    logic signed [rer_pkg::XcW-1:0] x_xc [3];
    rer_pkg::t_side          x_side;

    logic                    d_v;
    logic signed [rer_pkg::QW-1:0] d_nx, d_ny;
    logic                    d_sat;
    rer_pkg::t_side          d_side;

    logic                    p_v;
    rer_pkg::t_rsp           p_rsp;

    logic                    r_sk_v;
    rer_pkg::t_rsp           r_sk;

    // pipe advances unless the skid holds a response
    assign w_en        = !r_sk_v;
    assign i_req.ready = w_en;
    assign w_acc       = i_req.valid && w_en;

    assign w_cam_ok = 32'(i_req.data.cam_index) < 32'(MAX_CAMERAS);
    assign w_addr   = CamAw'(i_req.data.cam_index);
    assign w_we     = w_acc && (i_req.data.cmd == rer_pkg::CmdLoad) && w_cam_ok
                   && (i_req.data.word_sel <= rer_pkg::WordSelLast);

    rer_cam_store #(
        .MAX_CAMERAS (MAX_CAMERAS),
        .CAM_AW      (CamAw)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wsel  (i_req.data.word_sel),
        .i_wdata (i_req.data.load_value),
        .i_re    (w_en),
        .i_raddr (w_addr),
        .o_rdata (w_rd)
    );

    // read stage: observation fields alongside the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= w_acc && (i_req.data.cmd == rer_pkg::CmdEval);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_ok          <= w_cam_ok;
            r_s1_obs.point_x <= i_req.data.point_x;
            r_s1_obs.point_y <= i_req.data.point_y;
            r_s1_obs.point_z <= i_req.data.point_z;
            r_s1_obs.meas_u  <= i_req.data.meas_u;
            r_s1_obs.meas_v  <= i_req.data.meas_v;
        end
    end

    // out-of-range camera reads as all zero
    assign w_words = r_s1_ok ? w_rd : '0;

    rer_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_v     (r_s1_v),
        .i_words (w_words),
        .i_obs   (r_s1_obs),
        .o_v     (x_v),
        .o_xc    (x_xc),
        .o_side  (x_side)
    );

    rer_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_v     (x_v),
        .i_xc    (x_xc),
        .i_side  (x_side),
        .o_v     (d_v),
        .o_nx    (d_nx),
        .o_ny    (d_ny),
        .o_sat   (d_sat),
        .o_side  (d_side)
    );

    rer_distort u_distort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_v     (d_v),
        .i_nx    (d_nx),
        .i_ny    (d_ny),
        .i_sat   (d_sat),
        .i_side  (d_side),
        .o_v     (p_v),
        .o_rsp   (p_rsp)
    );

    // skid: catches the last stage when the pipe moves under a stalled response
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (o_rsp.ready) begin
                r_sk_v <= 1'b0;
            end
        end else if (p_v && !o_rsp.ready) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_v) begin
            r_sk <= p_rsp;
        end
    end

    assign o_rsp.valid = r_sk_v || p_v;
    assign o_rsp.data  = r_sk_v ? r_sk : p_rsp;

endmodule

/* rtl/rer_cam_store.sv */
// ----------------------------------------------------------------------------
// rer_cam_store
// Camera parameter memory: one row of fifteen words per camera, word-lane
// writes, one registered row read per cycle while i_re is high.
// ----------------------------------------------------------------------------
module rer_cam_store #(
    parameter int MAX_CAMERAS = rer_pkg::MaxCameras,
    parameter int CAM_AW      = 10
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [CAM_AW-1:0]                 i_waddr,
    input  logic [rer_pkg::WordSelW-1:0]      i_wsel,
    input  logic [rer_pkg::WordW-1:0]         i_wdata,
    input  logic                              i_re,
    input  logic [CAM_AW-1:0]                 i_raddr,
    output rer_pkg::t_cam_words               o_rdata
);

    rer_pkg::t_cam_words mem [MAX_CAMERAS];
    rer_pkg::t_cam_words r_rdata;

    // lane write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int l = 0; l < rer_pkg::Words; l++) begin
                if (i_wsel == rer_pkg::WordSelW'(l)) begin
                    mem[i_waddr][l] <= i_wdata;
                end
            end
        end
    end

    // row read, held while the pipe is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rer_xform.sv */
// ----------------------------------------------------------------------------
// rer_xform
// Rigid transform of the point into the camera frame: nine products, then
// the row sums plus translation.
// ----------------------------------------------------------------------------
module rer_xform (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_v,
    input  rer_pkg::t_cam_words                   i_words,
    input  rer_pkg::t_obs                         i_obs,
    output logic                                  o_v,
    output logic signed [rer_pkg::XcW-1:0]        o_xc [3],
    output rer_pkg::t_side                        o_side
);

    logic                               r_v_a;
    logic                               r_v_b;
    logic signed [63:0]                 r_prod [9];
    logic signed [rer_pkg::WordW-1:0]   r_t [3];
    rer_pkg::t_side                     r_side_a;
    rer_pkg::t_side                     r_side_b;
    logic signed [rer_pkg::XcW-1:0]     r_xc [3];
    logic signed [rer_pkg::WordW-1:0]   w_pt [3];
    logic signed [rer_pkg::XcW-1:0]     w_sum [3];

    assign w_pt[0] = i_obs.point_x;
    assign w_pt[1] = i_obs.point_y;
    assign w_pt[2] = i_obs.point_z;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
        end else if (i_en) begin
            r_v_a <= i_v;
            r_v_b <= r_v_a;
        end
    end

    // stage A: R*X products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int row = 0; row < 3; row++) begin
                for (int col = 0; col < 3; col++) begin
                    r_prod[3*row+col] <= $signed(i_words[3*row+col]) * w_pt[col];
                end
                r_t[row] <= $signed(i_words[rer_pkg::WordTx+row]);
            end
            r_side_a.meas_u <= i_obs.meas_u;
            r_side_a.meas_v <= i_obs.meas_v;
            r_side_a.f      <= $signed(i_words[rer_pkg::WordF]);
            r_side_a.k1     <= $signed(i_words[rer_pkg::WordK1]);
            r_side_a.k2     <= $signed(i_words[rer_pkg::WordK2]);
            r_side_a.zero   <= 1'b0;
        end
    end

    // stage B: floored products summed with t scaled to Q.32
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = rer_pkg::XcW'($signed(r_prod[3*k][63:14]))
                     + rer_pkg::XcW'($signed(r_prod[3*k+1][63:14]))
                     + rer_pkg::XcW'($signed(r_prod[3*k+2][63:14]))
                     + rer_pkg::XcW'($signed({r_t[k], 16'h0000}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_xc[k] <= w_sum[k];
            end
            r_side_b <= r_side_a;
        end
    end

    assign o_v    = r_v_b;
    assign o_xc   = r_xc;
    assign o_side = r_side_b;

endmodule

/* rtl/rer_div.sv */
// ----------------------------------------------------------------------------
// rer_div
// Pipelined restoring divider for the perspective divide: both image axes
// over the shared depth, one quotient bit per stage, Q4.28 result.
// ----------------------------------------------------------------------------
module rer_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_v,
    input  logic signed [rer_pkg::XcW-1:0]        i_xc [3],
    input  rer_pkg::t_side                        i_side,
    output logic                                  o_v,
    output logic signed [rer_pkg::QW-1:0]         o_nx,
    output logic signed [rer_pkg::QW-1:0]         o_ny,
    output logic                                  o_sat,
    output rer_pkg::t_side                        o_side
);

    localparam int QW   = rer_pkg::QW;
    localparam int RemW = rer_pkg::RemW;
    localparam int AbsW = rer_pkg::AbsW;
    localparam int XcW  = rer_pkg::XcW;

    // stage 0 is the operand prep, stages 1..QW the quotient bits
    logic                r_v   [QW+1];
    logic [RemW-1:0]     r_rx  [QW+1];
    logic [RemW-1:0]     r_ry  [QW+1];
    logic [QW-1:0]       r_qx  [QW+1];
    logic [QW-1:0]       r_qy  [QW+1];
    logic [AbsW-1:0]     r_b   [QW+1];
    logic                r_negx[QW+1];
    logic                r_negy[QW+1];
    rer_pkg::t_side      r_sd  [QW+1];
    logic                r_ox  [1:QW];
    logic                r_oy  [1:QW];

    logic                r_out_v;
    logic signed [QW-1:0] r_nx;
    logic signed [QW-1:0] r_ny;
    logic                r_sat;
    rer_pkg::t_side      r_out_sd;

    logic [AbsW-1:0]     w_ax, w_ay, w_b;
    logic                w_numx_neg, w_numy_neg, w_den_neg;
    rer_pkg::t_side      w_side;
    logic [RemW-1:0]     w_d   [QW];
    logic                w_gx  [QW];
    logic                w_gy  [QW];
    logic [RemW-1:0]     w_rx  [QW];
    logic [RemW-1:0]     w_ry  [QW];
    logic [RemW-1:0]     w_big;
    logic [QW:0]         w_limx, w_limy, w_magx, w_magy, w_mx, w_my, w_nmx, w_nmy;
    logic                w_satx, w_saty;

    function automatic logic [AbsW-1:0] abs_mag(input logic signed [XcW-1:0] v);
        logic signed [XcW-1:0] m;
        m = v[XcW-1] ? -v : v;
        return m[AbsW-1:0];
    endfunction

    // operand prep: magnitudes and sign of -xc/zc
    assign w_ax = abs_mag(i_xc[0]);
    assign w_ay = abs_mag(i_xc[1]);
    assign w_b  = abs_mag(i_xc[2]);
    assign w_numx_neg = !i_xc[0][XcW-1] && (i_xc[0] != '0);
    assign w_numy_neg = !i_xc[1][XcW-1] && (i_xc[1] != '0);
    assign w_den_neg  = i_xc[2][XcW-1];

    // side fields with the zero-depth flag
    always_comb begin
        w_side      = i_side;
        w_side.zero = (i_xc[2] == '0);
    end

    // one quotient bit per stage; divisor held at 8*b, remainder shifts up
    always_comb begin
        for (int j = 0; j < QW; j++) begin
            w_d[j]  = RemW'({r_b[j], 3'b000});
            w_gx[j] = r_rx[j] >= w_d[j];
            w_gy[j] = r_ry[j] >= w_d[j];
            w_rx[j] = w_gx[j] ? r_rx[j] - w_d[j] : r_rx[j];
            w_ry[j] = w_gy[j] ? r_ry[j] - w_d[j] : r_ry[j];
        end
    end

    // integer part of 16 or more cannot be represented
    assign w_big = {r_b[0], 4'b0000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= QW; j++) begin
                r_v[j] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_v;
            for (int j = 0; j < QW; j++) begin
                r_v[j+1] <= r_v[j];
            end
            r_out_v <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx[0]   <= RemW'(w_ax);
            r_ry[0]   <= RemW'(w_ay);
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_b[0]    <= w_b;
            r_negx[0] <= w_numx_neg ^ w_den_neg;
            r_negy[0] <= w_numy_neg ^ w_den_neg;
            r_sd[0]   <= w_side;
            for (int j = 0; j < QW; j++) begin
                r_rx[j+1]   <= {w_rx[j][RemW-2:0], 1'b0};
                r_ry[j+1]   <= {w_ry[j][RemW-2:0], 1'b0};
                r_qx[j+1]   <= {r_qx[j][QW-2:0], w_gx[j]};
                r_qy[j+1]   <= {r_qy[j][QW-2:0], w_gy[j]};
                r_b[j+1]    <= r_b[j];
                r_negx[j+1] <= r_negx[j];
                r_negy[j+1] <= r_negy[j];
                r_sd[j+1]   <= r_sd[j];
            end
            r_ox[1] <= r_rx[0] >= w_big;
            r_oy[1] <= r_ry[0] >= w_big;
            for (int j = 1; j < QW; j++) begin
                r_ox[j+1] <= r_ox[j];
                r_oy[j+1] <= r_oy[j];
            end
        end
    end

    // clip to the signed range and apply the sign
    always_comb begin
        w_limx = r_negx[QW] ? 33'h0_8000_0000 : 33'h0_7fff_ffff;
        w_limy = r_negy[QW] ? 33'h0_8000_0000 : 33'h0_7fff_ffff;
        w_magx = {1'b0, r_qx[QW]};
        w_magy = {1'b0, r_qy[QW]};
        w_satx = r_ox[QW] || (w_magx > w_limx);
        w_saty = r_oy[QW] || (w_magy > w_limy);
        w_mx   = w_satx ? w_limx : w_magx;
        w_my   = w_saty ? w_limy : w_magy;
        w_nmx  = (QW+1)'(0) - w_mx;
        w_nmy  = (QW+1)'(0) - w_my;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx     <= $signed(r_negx[QW] ? w_nmx[QW-1:0] : w_mx[QW-1:0]);
            r_ny     <= $signed(r_negy[QW] ? w_nmy[QW-1:0] : w_my[QW-1:0]);
            r_sat    <= w_satx || w_saty;
            r_out_sd <= r_sd[QW];
        end
    end

    assign o_v    = r_out_v;
    assign o_nx   = r_nx;
    assign o_ny   = r_ny;
    assign o_sat  = r_sat;
    assign o_side = r_out_sd;

endmodule

/* rtl/rer_distort.sv */
// ----------------------------------------------------------------------------
// rer_distort
// Radial distortion, focal scaling and residual: squared radius, the two
// polynomial steps, then n*r*f subtracted from the measurement.
// ----------------------------------------------------------------------------
module rer_distort (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_v,
    input  logic signed [rer_pkg::QW-1:0]         i_nx,
    input  logic signed [rer_pkg::QW-1:0]         i_ny,
    input  logic                                  i_sat,
    input  rer_pkg::t_side                        i_side,
    output logic                                  o_v,
    output rer_pkg::t_rsp                         o_rsp
);

    localparam int WordW = rer_pkg::WordW;

    // side fields and flags per stage
    logic                        r_vp   [1:9];
    rer_pkg::t_side              r_sdp  [1:8];
    logic signed [WordW-1:0]     r_nxp  [1:6];
    logic signed [WordW-1:0]     r_nyp  [1:6];
    logic                        r_satp [1:8];
    logic [WordW-1:0]            r_p2p  [3:4];

    logic signed [63:0]          r_sqx, r_sqy;
    logic [WordW-1:0]            r_p2;
    logic signed [64:0]          r_pk;
    logic signed [WordW-1:0]     r_s;
    logic signed [64:0]          r_ps;
    logic signed [WordW-1:0]     r_r;
    logic signed [63:0]          r_nrx, r_nry;
    logic signed [64:0]          r_mfx, r_mfy;
    rer_pkg::t_rsp               r_rsp;

    logic [63:0]                 w_sum;
    logic [WordW:0]              w_s, w_r, w_eu, w_ev;
    logic                        w_any_sat;

    assign w_sum = r_sqx + r_sqy;

    // s = k1 + p2*k2, r = 1 + p2*s
    assign w_s = rer_pkg::sat32(64'($signed(r_pk[64:24])) + 64'($signed(r_sdp[3].k1)));
    assign w_r = rer_pkg::sat32(rer_pkg::OneQ30 + 64'($signed(r_ps[64:24])));

    // residual
    assign w_eu = rer_pkg::sat32(64'($signed(r_sdp[8].meas_u))
                                 - 64'($signed(r_mfx[64:27])));
    assign w_ev = rer_pkg::sat32(64'($signed(r_sdp[8].meas_v))
                                 - 64'($signed(r_mfy[64:27])));
    assign w_any_sat = r_satp[8] || w_eu[WordW] || w_ev[WordW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 9; k++) begin
                r_vp[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vp[1] <= i_v;
            for (int k = 2; k <= 9; k++) begin
                r_vp[k] <= r_vp[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // carried fields
            r_sdp[1] <= i_side;
            for (int k = 2; k <= 8; k++) begin
                r_sdp[k] <= r_sdp[k-1];
            end
            r_nxp[1] <= i_nx;
            r_nyp[1] <= i_ny;
            for (int k = 2; k <= 6; k++) begin
                r_nxp[k] <= r_nxp[k-1];
                r_nyp[k] <= r_nyp[k-1];
            end
            r_satp[1] <= i_sat;
            r_satp[2] <= r_satp[1];
            r_satp[3] <= r_satp[2];
            r_satp[4] <= r_satp[3] || w_s[WordW];
            r_satp[5] <= r_satp[4];
            r_satp[6] <= r_satp[5] || w_r[WordW];
            r_satp[7] <= r_satp[6];
            r_satp[8] <= r_satp[7];
            r_p2p[3] <= r_p2;
            r_p2p[4] <= r_p2p[3];

            // stage 1: squares
            r_sqx <= i_nx * i_nx;
            r_sqy <= i_ny * i_ny;
            // stage 2: squared radius in Q8.24
            r_p2  <= w_sum[63:32];
            // stage 3: p2*k2
            r_pk  <= $signed({1'b0, r_p2}) * $signed(r_sdp[2].k2);
            // stage 4: s
            r_s   <= $signed(w_s[WordW-1:0]);
            // stage 5: p2*s
            r_ps  <= $signed({1'b0, r_p2p[4]}) * r_s;
            // stage 6: r
            r_r   <= $signed(w_r[WordW-1:0]);
            // stage 7: n*r
            r_nrx <= r_nxp[6] * r_r;
            r_nry <= r_nyp[6] * r_r;
            // stage 8: (n*r >> 31) * f
            r_mfx <= $signed(r_nrx[63:31]) * $signed(r_sdp[7].f);
            r_mfy <= $signed(r_nry[63:31]) * $signed(r_sdp[7].f);
            // stage 9: residual and status
            priority if (r_sdp[8].zero) begin
                r_rsp.err_u  <= '0;
                r_rsp.err_v  <= '0;
                r_rsp.status <= rer_pkg::StZero;
            end else begin
                r_rsp.err_u  <= $signed(w_eu[WordW-1:0]);
                r_rsp.err_v  <= $signed(w_ev[WordW-1:0]);
                r_rsp.status <= w_any_sat ? rer_pkg::StSat : rer_pkg::StOk;
            end
        end
    end

    assign o_v   = r_vp[9];
    assign o_rsp = r_rsp;

endmodule
